// ===== rtl/balanced_base_digit_decompose_defines.svh =====
// Assertion macros shared by the checker of the digit decomposer.
`ifndef BALANCED_BASE_DIGIT_DECOMPOSE_DEFINES_SVH
`define BALANCED_BASE_DIGIT_DECOMPOSE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define BDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bdd_pkg.sv =====
// Package: widths, register indexes and state codes of the digit decomposer.
`timescale 1ns / 1ps
`default_nettype none
package bdd_pkg;
	localparam int VALUE_BITS     = 60;
	localparam int BASE_BITS      = 32;
	localparam int COUNT_BITS     = 7;
	localparam int POS_BITS       = 6;
	localparam int MAX_DIGITS     = 64;
	localparam int DIV_BITS       = VALUE_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_BITS + 1);
	localparam int MOD_CNT_BITS   = $clog2(VALUE_BITS);
	localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((VALUE_BITS + POS_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = VALUE_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DIGIT_BASE   = 2'd0,
		CFG_RING_MODULUS = 2'd1,
		CFG_DIGIT_COUNT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_MOD  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/bdd_div_cell.sv =====
// One restoring-division cell: a quotient bit per cell, registered.
`timescale 1ns / 1ps
`default_nettype none
module bdd_div_cell import bdd_pkg::*; (
	input  logic                  clk,
	input  logic [BASE_BITS-1:0]  divisor,
	input  logic [BASE_BITS-1:0]  rem_in,
	input  logic [VALUE_BITS-1:0] word_in,
	output logic [BASE_BITS-1:0]  rem_s1,
	output logic [VALUE_BITS-1:0] word_s1
);
	logic [BASE_BITS:0] trial;
	logic               ge;
	logic [BASE_BITS:0] diff;

	// shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_in, word_in[VALUE_BITS-1]};
		ge    = (trial >= {1'b0, divisor});
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		rem_s1  <= ge ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
		word_s1 <= {word_in[VALUE_BITS-2:0], ge};
	end
endmodule
`default_nettype wire

// ===== rtl/bdd_mod.sv =====
// Iterative modulo unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bdd_mod import bdd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] modulus,
	output logic                  done,
	output logic [VALUE_BITS-1:0] rem
);
	logic                    busy_q;
	logic                    done_q;
	logic [MOD_CNT_BITS-1:0] cnt_q;
	logic [VALUE_BITS-1:0]   rem_q;
	logic [VALUE_BITS-1:0]   word_q;
	logic [VALUE_BITS:0]     trial;
	logic                    ge;
	logic [VALUE_BITS:0]     diff;

	always_comb begin
		trial = {rem_q, word_q[VALUE_BITS-1]};
		ge    = (trial >= {1'b0, modulus});
		diff  = trial - {1'b0, modulus};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_BITS'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			word_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			word_q <= {word_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/balanced_base_digit_decompose.sv =====
// Top level: balanced base-z digit decomposition of one value per transaction.
//
//  channel | direction | payload (low bit first)                | last
//  s_axis  | in        | value_in[59:0]                         | -
//  m_axis  | out       | digit_out[59:0], digit_position[65:60] | last_digit
//  cfg     | in        | cfg_index selects register, cfg_data   | -
//
// Each non-final digit waits in ST_DIV while the 60-cell chain settles, is
// balanced in ST_SUM, goes through the modulo unit in ST_MOD when the digit is
// negative and q is not zero, then holds in ST_EMIT until the digit is taken.
// The final digit skips the chain and goes straight to ST_SUM.
// Each value is first accepted in ST_IDLE; one value at a time.
// Reset restores base 2, modulus 2, count 1. Output stalls hold the digit.
`timescale 1ns / 1ps
`default_nettype none
module balanced_base_digit_decompose import bdd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // value_in
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // digit_out, digit_position
	output logic                      m_axis_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);
	logic [BASE_BITS-1:0]  base_q;
	logic [VALUE_BITS-1:0] modulus_q;
	logic [COUNT_BITS-1:0] count_q;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   remain_q;
	logic                    carry_q;
	logic [POS_BITS-1:0]     pos_q;
	logic [VALUE_BITS:0]     d_q;
	logic [VALUE_BITS-1:0]   digit_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    neg_q;

	logic [BASE_BITS-1:0]  z;
	logic [BASE_BITS-1:0]  half;
	logic [COUNT_BITS-1:0] t;
	logic [COUNT_BITS-1:0] t_m1;
	logic [POS_BITS-1:0]   last_pos;
	logic                  last_now;
	logic [VALUE_BITS:0]   z_w;
	logic                  d_is_z;
	logic                  d_big;
	logic                  d_ge;
	logic [VALUE_BITS:0]   d_diff;
	logic                  mod_start;
	logic                  mod_done;
	logic [VALUE_BITS-1:0] mod_rem;

	logic [BASE_BITS-1:0]  crem  [0:DIV_BITS];
	logic [VALUE_BITS-1:0] cword [0:DIV_BITS];

	// config register writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_BITS'(2);
			modulus_q <= VALUE_BITS'(2);
			count_q   <= COUNT_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DIGIT_BASE:   base_q    <= cfg_data[BASE_BITS-1:0];
				CFG_RING_MODULUS: modulus_q <= cfg_data[VALUE_BITS-1:0];
				CFG_DIGIT_COUNT:  count_q   <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamped settings and digit classification
	always_comb begin
		z        = (base_q < BASE_BITS'(2)) ? BASE_BITS'(2) : base_q;
		half     = z >> 1;
		if (count_q == '0)
			t = COUNT_BITS'(1);
		else if (count_q > COUNT_BITS'(MAX_DIGITS))
			t = COUNT_BITS'(MAX_DIGITS);
		else
			t = count_q;
		t_m1     = t - 1'b1;
		last_pos = t_m1[POS_BITS-1:0];
		last_now = (pos_q == last_pos);
		z_w      = {{(VALUE_BITS + 1 - BASE_BITS){1'b0}}, z};
		d_is_z   = (d_q == z_w);
		d_big    = (d_q > {{(VALUE_BITS + 1 - BASE_BITS){1'b0}}, half});
		d_ge     = (d_q >= z_w);
		d_diff   = d_ge ? (d_q - z_w) : (z_w - d_q);
		mod_start = (state_q == ST_SUM) && !d_is_z && d_big && (modulus_q != '0);
	end

	// division chain: quotient and remainder of remain_q by z
	assign crem[0]  = '0;
	assign cword[0] = remain_q;
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
		bdd_div_cell u_cell (
			.clk     (clk),
			.divisor (z),
			.rem_in  (crem[k]),
			.word_in (cword[k]),
			.rem_s1  (crem[k+1]),
			.word_s1 (cword[k+1])
		);
	end

	bdd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (d_diff[VALUE_BITS-1:0]),
		.modulus  (modulus_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			carry_q <= 1'b0;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						carry_q <= 1'b0;
						pos_q   <= '0;
						cnt_q   <= '0;
						state_q <= (last_pos == '0) ? ST_SUM : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_BITS'(DIV_BITS))
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (d_is_z || d_big) begin
						carry_q <= 1'b1;
						state_q <= mod_start ? ST_MOD : ST_EMIT;
					end else begin
						carry_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_MOD: begin
					if (mod_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						if (last_now) begin
							state_q <= ST_IDLE;
							carry_q <= 1'b0;
							pos_q   <= '0;
						end else begin
							pos_q   <= pos_q + 1'b1;
							cnt_q   <= '0;
							state_q <= ((pos_q + 1'b1) == last_pos) ? ST_SUM : ST_DIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					remain_q <= s_axis_tdata[VALUE_BITS-1:0];
					d_q      <= {1'b0, s_axis_tdata[VALUE_BITS-1:0]};
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_CNT_BITS'(DIV_BITS)) begin
					d_q      <= {{(VALUE_BITS + 1 - BASE_BITS){1'b0}}, crem[DIV_BITS]}
						+ {{VALUE_BITS{1'b0}}, carry_q};
					remain_q <= cword[DIV_BITS];
				end
			end
			ST_SUM: begin
				neg_q <= !d_ge;
				if (d_is_z)
					digit_q <= '0;
				else if (d_big)
					digit_q <= d_q[VALUE_BITS-1:0] - z_w[VALUE_BITS-1:0];
				else
					digit_q <= d_q[VALUE_BITS-1:0];
			end
			ST_MOD: begin
				if (mod_done) begin
					if (!neg_q)
						digit_q <= mod_rem;
					else if (mod_rem == '0)
						digit_q <= '0;
					else
						digit_q <= modulus_q - mod_rem;
				end
			end
			ST_EMIT: begin
				if (m_axis_tready && !last_now)
					d_q <= {1'b0, remain_q} + {{VALUE_BITS{1'b0}}, carry_q};
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tlast  = last_now;
	assign m_axis_tdata  = {{(OUT_TDATA_BITS - VALUE_BITS - POS_BITS){1'b0}}, pos_q, digit_q};
endmodule
`default_nettype wire

// ===== rtl/bdd_checker.sv =====
// Port-level checker for the digit decomposer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "balanced_base_digit_decompose_defines.svh"
module bdd_checker import bdd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // digit_out, digit_position
	input logic                      m_axis_tlast
);
	logic in_txn;
	logic out_txn;

	assign in_txn  = s_axis_tvalid && s_axis_tready;
	assign out_txn = m_axis_tvalid && m_axis_tready;

	// a stalled digit holds
	`BDD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed under stall")
	// no new value while a digit is pending
	`BDD_ASSERT_NOW(a_one_value, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input ready with digit pending")
	// after a value is taken the block is busy and has no digit yet
	`BDD_ASSERT_NEXT(a_busy, clk, arst_n, in_txn, !s_axis_tready && !m_axis_tvalid, "not busy after input transaction")
	// after the final digit the block goes idle
	`BDD_ASSERT_NEXT(a_done, clk, arst_n, out_txn && m_axis_tlast, !m_axis_tvalid && s_axis_tready, "not idle after final digit")
endmodule

bind balanced_base_digit_decompose bdd_checker u_bdd_checker (.*);
`default_nettype wire

// ===== verif/tb_balanced_base_digit_decompose.sv =====
// Testbench: balanced base-z digit decomposer against a cycle-free digit predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_balanced_base_digit_decompose;
	import bdd_pkg::*;

	typedef struct packed {
		logic [VALUE_BITS-1:0] digit;
		logic [POS_BITS-1:0]   pos;
		logic                  last;
	} digit_t;

	localparam logic [63:0] VMASK = (64'd1 << VALUE_BITS) - 64'd1;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;   // value_in
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;        // digit_out, digit_position
	logic                      m_axis_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	cfg_idx_t                  cfg_index = CFG_DIGIT_BASE;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// Shadow registers of the block
	logic [BASE_BITS-1:0]  base_reg;
	logic [VALUE_BITS-1:0] mod_reg;
	logic [COUNT_BITS-1:0] count_reg;

	digit_t pending_digits[$];
	int     values_taken = 0;
	int     writes_taken = 0;
	int     mismatches = 0;
	int     failures = 0;
	bit     calm = 1'b0;

	balanced_base_digit_decompose uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// (d - z) mod q; q of zero wraps at the value width
	function automatic logic [63:0] wrap_negative(logic [63:0] d, logic [63:0] z,
			logic [63:0] q);
		if (q == 0) begin
			return (d - z) & VMASK;
		end
		return ((d % q) + (q - (z % q))) % q;
	endfunction

	// Expected balanced digits of one value under the current settings
	task automatic predict_digits(logic [63:0] v);
		logic [63:0] z, q, half, t, rest, raw, d, emit;
		logic        carry;
		digit_t      e;
		z = (base_reg < 2) ? 64'd2 : 64'(base_reg);
		q = 64'(mod_reg);
		half = z >> 1;
		t = 64'(count_reg);
		if (t < 1) t = 1;
		if (t > MAX_DIGITS) t = MAX_DIGITS;
		rest = v & VMASK;
		carry = 1'b0;
		for (int i = 0; i < t; i++) begin
			if (i + 1 == t) begin
				raw = rest;
			end else begin
				raw = rest % z;
				rest = rest / z;
			end
			d = raw + carry;
			if (d == z) begin
				emit = 0;
				carry = 1'b1;
			end else if (d > half) begin
				emit = wrap_negative(d, z, q);
				carry = 1'b1;
			end else begin
				emit = d;
				carry = 1'b0;
			end
			e.digit = emit[VALUE_BITS-1:0];
			e.pos = POS_BITS'(i);
			e.last = (i + 1 == t);
			pending_digits = {pending_digits, e};
		end
	endtask

	// Input and configuration transactions, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			writes_taken <= writes_taken + 1;
			case (cfg_index)
				CFG_DIGIT_BASE: begin
					base_reg = cfg_data[BASE_BITS-1:0];
				end
				CFG_RING_MODULUS: begin
					mod_reg = cfg_data;
				end
				CFG_DIGIT_COUNT: begin
					count_reg = cfg_data[COUNT_BITS-1:0];
				end
				default: ;
			endcase
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			values_taken <= values_taken + 1;
			predict_digits(64'(s_axis_tdata[VALUE_BITS-1:0]));
		end
	end

	// Result check against the oldest expected digit
	always @(posedge clk) begin
		digit_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.digit = m_axis_tdata[VALUE_BITS-1:0];
			got.pos = m_axis_tdata[VALUE_BITS +: POS_BITS];
			got.last = m_axis_tlast;
			if (pending_digits.size() == 0) begin
				failures++;
				if (mismatches < 10)
					$display("unexpected digit %h pos %0d last %0b",
						got.digit, got.pos, got.last);
				mismatches++;
			end else begin
				want = pending_digits.pop_front();
				if (got !== want) begin
					failures++;
					if (mismatches < 10)
						$display("digit mismatch: exp %h pos %0d last %0b, got %h pos %0d last %0b",
							want.digit, want.pos, want.last, got.digit, got.pos, got.last);
					mismatches++;
				end
			end
		end
	end

	// Receiver backpressure in random bursts
	always @(negedge clk) begin
		int hold;
		if (calm) begin
			m_axis_tready = 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready = 1'b0;
			hold = $urandom_range(1, 19);
			repeat (hold) @(negedge clk);
			m_axis_tready = 1'b1;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	task automatic send_value(logic [63:0] v);
		int target;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		target = values_taken + 1;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = '0;
		s_axis_tdata[VALUE_BITS-1:0] = v[VALUE_BITS-1:0];
		do @(negedge clk); while (values_taken != target);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		int target;
		target = writes_taken + 1;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_DATA_BITS-1:0];
		do @(negedge clk); while (writes_taken != target);
		cfg_valid = 1'b0;
	endtask

	// Let every expected digit drain, then a few quiet cycles
	task automatic wait_drained();
		while (pending_digits.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_all(logic [63:0] z, logic [63:0] q, logic [63:0] t);
		wait_drained();
		write_reg(CFG_DIGIT_BASE, z);
		write_reg(CFG_RING_MODULUS, q);
		write_reg(CFG_DIGIT_COUNT, t);
	endtask

	function automatic logic [63:0] rand60();
		return {$urandom, $urandom} & VMASK;
	endfunction

	// Number of base-z digits of q, as software would program it
	function automatic logic [63:0] digits_of(logic [63:0] q, logic [63:0] z);
		logic [63:0] n;
		n = 0;
		if (z < 2) z = 2;
		while (q > 0) begin
			q = q / z;
			n++;
		end
		return (n == 0) ? 1 : n;
	endfunction

	task automatic test_reset_defaults();
		send_value(0);
		send_value(1);
		send_value(5);
		send_value(VMASK);
	endtask

	task automatic test_balanced_carries();
		// decimal: half stays, six goes negative, nine plus carry hits the base
		set_all(10, 1000, 3);
		send_value(0);
		send_value(999);
		send_value(995);
		send_value(456);
		send_value(96);
		send_value(123456);   // too wide, top digit exceeds base
		set_all(3, 81, 4);
		send_value(80);
		send_value(41);
	endtask

	task automatic test_extremes();
		set_all(0, 0, 0);     // base and count below range, modulus wraps
		send_value(3);
		send_value(VMASK);
		set_all(1, 1, 5);     // every negative digit encodes to zero
		send_value(27);
		send_value(VMASK);
		set_all(32'hFFFF_FFFF, VMASK, 2);
		send_value(VMASK);
		send_value(64'h7FFF_FFFF);
		send_value(64'h8000_0000);
		set_all(2, VMASK, 64);
		send_value(VMASK);
		send_value(64'h0AAA_AAAA_AAAA_AAAA);
		set_all(4, 1000, 127); // clamps to the maximum count
		send_value(999);
	endtask

	task automatic test_random();
		logic [63:0] z, q, t, v;
		for (int phase = 0; phase < 11; phase++) begin
			case ($urandom_range(0, 4))
				0: z = $urandom_range(2, 16);
				1: z = $urandom_range(17, 4096);
				2: z = $urandom;
				3: z = $urandom_range(0, 1);
				default: z = 32'hFFFF_FFFF - $urandom_range(0, 3);
			endcase
			if (z < 17)
				q = rand60() >> $urandom_range(38, 58);
			else
				q = rand60() >> $urandom_range(0, 40);
			if ($urandom_range(0, 9) == 0) q = $urandom_range(0, 1);
			t = digits_of(q, z);
			if ($urandom_range(0, 5) == 0) t = $urandom_range(0, 9);
			if (phase == 10) begin
				wait_drained();
				calm = 1'b1;
			end
			set_all(z, q, t);
			for (int k = 0; k < 30; k++) begin
				if (q > 1 && $urandom_range(0, 4) != 0)
					v = rand60() % q;
				else
					v = rand60();
				send_value(v);
			end
		end
	endtask

	initial begin
		base_reg = 2;
		mod_reg = 2;
		count_reg = 1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_balanced_carries();
		test_extremes();
		test_random();
		wait_drained();
		repeat (200) @(negedge clk);
		if (failures == 0 && pending_digits.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#500_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/bdd_pkg.sv
rtl/bdd_div_cell.sv
rtl/bdd_mod.sv
rtl/balanced_base_digit_decompose.sv
rtl/bdd_checker.sv
verif/tb_balanced_base_digit_decompose.sv
